>>> rtl/vdi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_pkg
// shared types and constants of the vertex dedup indexer
// ----------------------------------------------------------------------------
package vdi_pkg;

    localparam int DefaultTableDepth = 1024;
    localparam int IndexWidth        = 10;
    localparam int CfgIndexWidth     = 2;

    localparam logic [CfgIndexWidth-1:0] CFG_COMPARE_NORMAL   = 2'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_COMPARE_TEXCOORD = 2'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_COMPARE_TANGENT  = 2'd2;

    typedef struct packed {
        logic        first_of_mesh;
        logic [31:0] position_x;
        logic [31:0] position_y;
        logic [31:0] position_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
        logic [63:0] texcoord_pair;
        logic [63:0] tangent_low_pair;
        logic [63:0] tangent_high_pair;
    } vdi_in_t;

    typedef struct packed {
        logic [IndexWidth-1:0] vertex_index;
        logic                  is_new;
        logic                  table_full;
    } vdi_out_t;

    // stored vertex, without the mesh flag
    typedef struct packed {
        logic [31:0] position_x;
        logic [31:0] position_y;
        logic [31:0] position_z;
        logic [31:0] normal_x;
        logic [31:0] normal_y;
        logic [31:0] normal_z;
        logic [63:0] texcoord_pair;
        logic [63:0] tangent_low_pair;
        logic [63:0] tangent_high_pair;
    } vdi_vertex_t;

    typedef struct packed {
        logic compare_normal;
        logic compare_texcoord;
        logic compare_tangent;
    } vdi_cfg_t;

    function automatic logic single_eq(input logic [31:0] a, input logic [31:0] b);
        logic a_nan;
        logic b_nan;
        a_nan = (a[30:0] > 31'h7F800000);
        b_nan = (b[30:0] > 31'h7F800000);
        if (a_nan || b_nan) begin
            return 1'b0;
        end
        if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
            return 1'b1;
        end
        return a == b;
    endfunction

    function automatic logic pair_eq(input logic [63:0] a, input logic [63:0] b);
        return single_eq(a[31:0], b[31:0]) && single_eq(a[63:32], b[63:32]);
    endfunction

    function automatic logic vertex_match(input vdi_vertex_t a, input vdi_vertex_t b,
                                          input vdi_cfg_t cfg);
        logic eq;
        eq = single_eq(a.position_x, b.position_x) && single_eq(a.position_y, b.position_y)
             && single_eq(a.position_z, b.position_z);
        if (cfg.compare_normal) begin
            eq = eq && single_eq(a.normal_x, b.normal_x) && single_eq(a.normal_y, b.normal_y)
                 && single_eq(a.normal_z, b.normal_z);
        end
        if (cfg.compare_texcoord) begin
            eq = eq && pair_eq(a.texcoord_pair, b.texcoord_pair);
        end
        if (cfg.compare_tangent) begin
            eq = eq && pair_eq(a.tangent_low_pair, b.tangent_low_pair)
                 && pair_eq(a.tangent_high_pair, b.tangent_high_pair);
        end
        return eq;
    endfunction

endpackage

>>> rtl/vdi_table_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vdi_table_ram
// unique vertex store, one write and one registered read port
// ----------------------------------------------------------------------------
module vdi_table_ram
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = DefaultTableDepth,
    localparam int AddrWidth  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                 aclk,
    input  logic                 wr_en,
    input  logic [AddrWidth-1:0] wr_addr,
    input  vdi_vertex_t          wr_data,
    input  logic [AddrWidth-1:0] rd_addr,
    output vdi_vertex_t          rd_data
);

    vdi_vertex_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/vertex_dedup_indexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_dedup_indexer
// index buffer builder that removes duplicate vertices
// ----------------------------------------------------------------------------
// One vertex at a time: the unique table sits in a single-port-read memory
// and is scanned in insertion order, one entry at a time (a read step, then
// a compare step), stopping at the first hit. A miss appends the vertex; a
// miss on a full table returns index 0 with table_full.
// first_of_mesh empties the table. The result sits in an output register
// until taken; the next vertex is accepted in the cycle after it is.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer
    import vdi_pkg::*;
#(
    parameter int TABLE_DEPTH = DefaultTableDepth,
    localparam int AddrWidth  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CountWidth = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  vdi_in_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output vdi_out_t                 m_data,
    input  logic                     cfg_we,
    input  logic [CfgIndexWidth-1:0] cfg_index,
    input  logic                     cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;

    logic [2:0]            state_reg, state_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [CountWidth-1:0] scan_reg, scan_next;
    vdi_cfg_t              cfg_reg;
    vdi_vertex_t           vtx_reg;
    vdi_out_t              out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  wr_en;
    logic [AddrWidth-1:0]  rd_addr;
    vdi_vertex_t           rd_data;
    logic                  hit;

    vdi_table_ram #(.TABLE_DEPTH(TABLE_DEPTH)) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AddrWidth-1:0]),
        .wr_data (vtx_reg),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign rd_addr = scan_reg[AddrWidth-1:0];
    assign hit     = vertex_match(vtx_reg, rd_data, cfg_reg);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        wr_en        = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    scan_next = '0;
                    if (s_data.first_of_mesh) begin
                        count_next = '0;
                    end
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                // address scan_reg presented, data valid next cycle
                if (scan_reg == count_reg) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (hit) begin
                    out_next.vertex_index = IndexWidth'(scan_reg);
                    out_next.is_new       = 1'b0;
                    out_next.table_full   = 1'b0;
                    m_valid_next          = 1'b1;
                    state_next            = ST_IDLE;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_DONE: begin
                if (count_reg == CountWidth'(TABLE_DEPTH)) begin
                    out_next.vertex_index = '0;
                    out_next.is_new       = 1'b0;
                    out_next.table_full   = 1'b1;
                end else begin
                    wr_en                 = 1'b1;
                    out_next.vertex_index = IndexWidth'(count_reg);
                    out_next.is_new       = 1'b1;
                    out_next.table_full   = 1'b0;
                    count_next            = count_reg + 1'b1;
                end
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            scan_reg    <= '0;
            m_valid_reg <= 1'b0;
            cfg_reg     <= '{compare_normal: 1'b1, compare_texcoord: 1'b1,
                             compare_tangent: 1'b1};
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            scan_reg    <= scan_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_COMPARE_NORMAL:   cfg_reg.compare_normal   <= cfg_data;
                    CFG_COMPARE_TEXCOORD: cfg_reg.compare_texcoord <= cfg_data;
                    CFG_COMPARE_TANGENT:  cfg_reg.compare_tangent  <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
        if (s_valid && s_ready) begin
            vtx_reg <= '{position_x: s_data.position_x, position_y: s_data.position_y,
                         position_z: s_data.position_z, normal_x: s_data.normal_x,
                         normal_y: s_data.normal_y, normal_z: s_data.normal_z,
                         texcoord_pair: s_data.texcoord_pair,
                         tangent_low_pair: s_data.tangent_low_pair,
                         tangent_high_pair: s_data.tangent_high_pair};
        end
    end

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CountWidth'(TABLE_DEPTH))
        else $error("unique count beyond table depth");

    a_scan_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> scan_reg < count_reg)
        else $error("scan past filled entries");

    a_new_grows_count: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |=> count_reg == $past(count_reg) + 1'b1)
        else $error("append without count step");

    a_result_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.is_new && m_data.table_full))
        else $error("new and full together");

endmodule
